// ----- hdl/phsms_pkg.sv -----
`timescale 1ns / 1ps
package phsms_pkg;

	// fixed field widths
	localparam int KEY_W    = 64;
	localparam int TAG_W    = 16;
	localparam int LIVE_W   = 6;
	localparam int THR_W    = 17;
	localparam int MAX_AW   = 7;

	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [THR_W-1:0] DEFAULT_THR = 17'd100;

	// request modes
	localparam logic [1:0] MODE_RESTART = 2'd0;
	localparam logic [1:0] MODE_INSERT  = 2'd1;
	localparam logic [1:0] MODE_MARK    = 2'd2;
	localparam logic [1:0] MODE_SWEEP   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_NULL    = 3'd3;
	localparam logic [2:0] ST_MARKED  = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_PRD, S_PCMP, S_EMIT,
		S_CRD, S_CCHK, S_THR,
		S_SRD, S_SCHK, S_SHASH, S_SPUT, S_SNEXT
	} ctl_state_t;

	typedef enum logic [1:0] {
		H_IDLE, H_MUL, H_RED
	} hash_state_t;

	// slot table controls
	typedef struct packed {
		logic              rd_en;
		logic [MAX_AW-1:0] rd_addr;
		logic              wr_en;
		logic [MAX_AW-1:0] wr_addr;
		logic              clr_all;
		logic              clr_bank_en;
		logic              clr_bank;
		logic              clr_one_en;
		logic [MAX_AW-1:0] clr_one_addr;
		logic [MAX_AW-1:0] chk_addr;
	} tbl_ctl_t;

endpackage

// ----- hdl/phsms_hash.sv -----
`timescale 1ns / 1ps
module phsms_hash #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [phsms_pkg::KEY_W-1:0]   key,
	output logic                          done,
	output logic [$clog2(CAPACITY)-1:0]   home
);
	import phsms_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam bit IS_POW2 = ((1 << IW) == CAPACITY);

	generate
		if (IS_POW2) begin : g_pow2
			// low bits of the product only depend on low bits of the operands
			logic [IW-1:0]   prod;
			logic            done_q;
			logic [IW-1:0]   home_q;

			assign prod = key[IW+2:3] * GOLDEN[IW-1:0];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= prod;
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_serial
			// shift-add multiply, then fold the product one byte a cycle:
			// r = (r * 256 + byte) mod CAPACITY, both terms from constant tables
			localparam int RN = 1 << IW;
			hash_state_t    phase_q;
			logic [5:0]     cnt_q;
			logic           done_q;
			logic [63:0]    acc_q;
			logic [63:0]    mc_q;
			logic [60:0]    mp_q;
			logic [IW-1:0]  r_q;
			logic [IW-1:0]  r_shift [RN];
			logic [IW-1:0]  byte_mod [256];
			logic [IW:0]    t;

			for (genvar g = 0; g < RN; g++) begin : g_rtab
				assign r_shift[g] = IW'((g * 256) % CAPACITY);
			end
			for (genvar g = 0; g < 256; g++) begin : g_btab
				assign byte_mod[g] = IW'(g % CAPACITY);
			end

			// both terms are below CAPACITY, one subtract brings the sum back
			assign t = {1'b0, r_shift[r_q]} + {1'b0, byte_mod[acc_q[63:56]]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					phase_q <= H_IDLE;
					cnt_q   <= '0;
					done_q  <= 1'b0;
				end else begin
					done_q <= 1'b0;
					case (phase_q)
						H_IDLE: begin
							if (start) begin
								phase_q <= H_MUL;
								cnt_q   <= '0;
							end
						end
						H_MUL: begin
							cnt_q <= cnt_q + 6'd1;
							if (cnt_q == 6'd60) begin
								phase_q <= H_RED;
								cnt_q   <= '0;
							end
						end
						H_RED: begin
							cnt_q <= cnt_q + 6'd1;
							if (cnt_q == 6'd7) begin
								phase_q <= H_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: phase_q <= H_IDLE;
					endcase
				end
			end

			always_ff @(posedge clk) begin
				case (phase_q)
					H_IDLE: begin
						acc_q <= '0;
						mc_q  <= GOLDEN;
						mp_q  <= key[63:3];
						r_q   <= '0;
					end
					H_MUL: begin
						if (mp_q[0]) begin
							acc_q <= acc_q + mc_q;
						end
						mc_q <= {mc_q[62:0], 1'b0};
						mp_q <= {1'b0, mp_q[60:1]};
					end
					H_RED: begin
						r_q   <= (t >= (IW+1)'(CAPACITY)) ? IW'(t - (IW+1)'(CAPACITY)) : IW'(t);
						acc_q <= {acc_q[55:0], 8'h00};
					end
					default: r_q <= r_q;
				endcase
			end

			assign done = done_q;
			assign home = r_q;
		end
	endgenerate

endmodule

// ----- hdl/phsms_table.sv -----
`timescale 1ns / 1ps
module phsms_table #(
	parameter int CAPACITY = 64,
	parameter int DW = 81
) (
	input  logic                clk,
	input  logic                arst_n,
	input  phsms_pkg::tbl_ctl_t ctl,
	input  logic [DW-1:0]       wr_data,
	output logic [DW-1:0]       rd_data,
	output logic                rd_valid,
	output logic                chk_valid
);
	import phsms_pkg::*;

	localparam int DEPTH = 2 * CAPACITY;
	localparam int AW = $clog2(DEPTH);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_data_q;
	logic             rd_valid_q;
	logic [AW-1:0]    ra, wa, ca, chk;

	assign ra  = ctl.rd_addr[AW-1:0];
	assign wa  = ctl.wr_addr[AW-1:0];
	assign ca  = ctl.clr_one_addr[AW-1:0];
	assign chk = ctl.chk_addr[AW-1:0];

	// slot storage, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wa] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ra];
		end
	end

	// occupancy bits: clears first, a write sets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (ctl.clr_all) begin
					valid_q[k] <= 1'b0;
				end else if (ctl.clr_bank_en && ((k >= CAPACITY) == ctl.clr_bank)) begin
					valid_q[k] <= 1'b0;
				end else if (ctl.clr_one_en && (k == int'(ca))) begin
					valid_q[k] <= 1'b0;
				end
				if (ctl.wr_en && (k == int'(wa))) begin
					valid_q[k] <= 1'b1;
				end
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ra];
			end
		end
	end

	assign rd_data   = rd_data_q;
	assign rd_valid  = rd_valid_q;
	assign chk_valid = valid_q[chk];

endmodule

// ----- hdl/pointer_hash_set_mark_sweep_top.sv -----
`timescale 1ns / 1ps
// Restart and null-key requests go straight to the result stage, with no hash or probe.
// Insert/mark: hash (registered when CAPACITY is a power of two, serial shift-add and
// byte fold otherwise), then a read and a compare per probed slot; the single read
// port of the slot memory sets the probe rate. Sweep: count the active bank, update the
// threshold, then per slot read and check, emit each freed key, rehash survivors into
// the other bank; one request at a time, input stalls meanwhile.
// Reset (arst_n low) empties both banks, selects bank 0, threshold and register 100.
module pointer_hash_set_mark_sweep_top #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     mode,
	input  logic [phsms_pkg::KEY_W-1:0]    key,
	input  logic [phsms_pkg::TAG_W-1:0]    type_tag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic                           collect_due,
	output logic                           freed_valid,
	output logic [phsms_pkg::KEY_W-1:0]    freed_key,
	output logic [phsms_pkg::TAG_W-1:0]    entry_tag,
	output logic [phsms_pkg::LIVE_W-1:0]   live_count,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [15:0]                    cfg_wdata
);
	import phsms_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int AW = $clog2(2 * CAPACITY);
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int DW = 1 + TW + KEY_W;
	localparam int NW = $clog2(CAPACITY + 1);
	localparam logic [8:0] FULL_LIM = 9'(CAPACITY * 3);

	function automatic logic [AW-1:0] slot_addr(input logic b, input logic [IW-1:0] ix);
		return b ? (AW'(CAPACITY) + AW'(ix)) : AW'(ix);
	endfunction

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] ix);
		return (ix == IW'(CAPACITY - 1)) ? '0 : ix + IW'(1);
	endfunction

	ctl_state_t state_q, state_d, ret_q;

	// request and working registers
	logic [1:0]        mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [TW-1:0]     tag_q;
	logic              bank_q;
	logic [LIVE_W-1:0] live_q;
	logic [THR_W-1:0]  thr_q;
	logic [15:0]       init_q;
	logic [IW-1:0]     idx_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     surv_q, nf_q, fc_q;

	// probe position in the other bank during sweep
	logic [IW-1:0]     h_home_q;

	// pending result
	logic [2:0]        res_st_q;
	logic              res_due_q, res_fv_q, res_last_q;
	logic [KEY_W-1:0]  res_fk_q;
	logic [TW-1:0]     res_tag_q;

	// output register
	logic              ov_q;
	logic [2:0]        status_q;
	logic              due_q, fv_q, last_q;
	logic [KEY_W-1:0]  fk_q;
	logic [TAG_W-1:0]  etag_q;
	logic [LIVE_W-1:0] lc_q;

	tbl_ctl_t         tctl;
	logic [DW-1:0]    wr_data, rd_data;
	logic             rd_valid, chk_valid;
	logic             h_start, h_done;
	logic [KEY_W-1:0] h_key;
	logic [IW-1:0]    h_home;

	logic [KEY_W-1:0] rd_key;
	logic [TW-1:0]    rd_tag;
	logic             rd_mark;
	logic             in_xfer, out_free, hit, probe_end, full, last_slot;

	assign rd_key    = rd_data[KEY_W-1:0];
	assign rd_tag    = rd_data[KEY_W +: TW];
	assign rd_mark   = rd_data[DW-1];
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !ov_q || out_ready;
	assign hit       = rd_valid && (rd_key == key_q);
	assign probe_end = !rd_valid || hit || (n_q == NW'(CAPACITY - 1));
	assign full      = {(7'(live_q) + 7'd1), 2'b00} >= FULL_LIM;
	assign last_slot = (idx_q == IW'(CAPACITY - 1));

	phsms_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.key    (h_key),
		.done   (h_done),
		.home   (h_home)
	);

	phsms_table #(.CAPACITY(CAPACITY), .DW(DW)) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tctl),
		.wr_data   (wr_data),
		.rd_data   (rd_data),
		.rd_valid  (rd_valid),
		.chk_valid (chk_valid)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (mode == MODE_SWEEP) begin
						state_d = S_CRD;
					end else if (mode == MODE_RESTART || key == '0) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH:  if (h_done) state_d = S_PRD;
			S_PRD:   state_d = S_PCMP;
			S_PCMP:  state_d = probe_end ? S_EMIT : S_PRD;
			S_EMIT:  if (out_free) state_d = ret_q;
			S_CRD:   state_d = S_CCHK;
			S_CCHK:  state_d = last_slot ? S_THR : S_CRD;
			S_THR: begin
				if (thr_q != '0 && !({11'b0, live_q} > (thr_q >> 1))) begin
					state_d = S_SRD;
				end
			end
			S_SRD:   state_d = S_SCHK;
			S_SCHK: begin
				if (!rd_valid) begin
					state_d = S_SNEXT;
				end else if (rd_mark) begin
					state_d = S_SHASH;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_SHASH: if (h_done) state_d = S_SPUT;
			S_SPUT:  if (!chk_valid) state_d = S_SNEXT;
			S_SNEXT: begin
				if (!last_slot) begin
					state_d = S_SRD;
				end else if (nf_q == '0) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		tctl     = '0;
		wr_data  = {1'b0, tag_q, key_q};
		h_start  = 1'b0;
		h_key    = key;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					tctl.clr_all     = (mode == MODE_RESTART);
					tctl.clr_bank_en = (mode == MODE_SWEEP);
					tctl.clr_bank    = !bank_q;
					h_start = (mode == MODE_INSERT || mode == MODE_MARK) && (key != '0);
				end
			end
			S_PRD: begin
				tctl.rd_en   = 1'b1;
				tctl.rd_addr = MAX_AW'(slot_addr(bank_q, idx_q));
			end
			S_PCMP: begin
				tctl.wr_addr = MAX_AW'(slot_addr(bank_q, idx_q));
				if (mode_q == MODE_INSERT) begin
					tctl.wr_en = !rd_valid && !full;
				end else begin
					tctl.wr_en = hit && !rd_mark;
					wr_data    = {1'b1, rd_tag, rd_key};
				end
			end
			S_CRD, S_SRD: begin
				tctl.rd_en   = 1'b1;
				tctl.rd_addr = MAX_AW'(slot_addr(bank_q, idx_q));
			end
			S_SCHK: begin
				tctl.clr_one_en   = rd_valid;
				tctl.clr_one_addr = MAX_AW'(slot_addr(bank_q, idx_q));
				h_start = rd_valid && rd_mark;
				h_key   = rd_key;
			end
			S_SPUT: begin
				tctl.chk_addr = MAX_AW'(slot_addr(!bank_q, h_home_q));
				tctl.wr_addr  = MAX_AW'(slot_addr(!bank_q, h_home_q));
				tctl.wr_en    = !chk_valid;
				wr_data       = {1'b0, rd_tag, rd_key};
			end
			default: tctl = '0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			bank_q  <= 1'b0;
			live_q  <= '0;
			thr_q   <= DEFAULT_THR;
			init_q  <= 16'(DEFAULT_THR);
			idx_q   <= '0;
			n_q     <= '0;
			surv_q  <= '0;
			nf_q    <= '0;
			fc_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ret_q <= S_IDLE;
					idx_q <= '0;
					surv_q <= '0;
					nf_q   <= '0;
					if (in_xfer && mode == MODE_RESTART) begin
						bank_q <= 1'b0;
						live_q <= '0;
						thr_q  <= (init_q != '0) ? THR_W'(init_q) : DEFAULT_THR;
					end
				end
				S_HASH: begin
					idx_q <= h_home;
					n_q   <= '0;
				end
				S_PCMP: begin
					if (!probe_end) begin
						idx_q <= next_idx(idx_q);
						n_q   <= n_q + NW'(1);
					end else if (mode_q == MODE_INSERT && !hit && !full) begin
						live_q <= live_q + LIVE_W'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
					end
				end
				S_CCHK: begin
					if (rd_valid && rd_mark) begin
						surv_q <= surv_q + NW'(1);
					end else if (rd_valid) begin
						nf_q <= nf_q + NW'(1);
					end
					idx_q <= next_idx(idx_q);
					if (last_slot) begin
						live_q <= LIVE_W'(surv_q + NW'(rd_valid && rd_mark));
					end
				end
				S_THR: begin
					fc_q <= '0;
					if (thr_q == '0) begin
						thr_q <= THR_W'(1);
					end else if ({11'b0, live_q} > (thr_q >> 1)) begin
						thr_q <= {thr_q[THR_W-2:0], 1'b0};
					end
				end
				S_SCHK: begin
					ret_q <= S_SNEXT;
					if (rd_valid && !rd_mark) begin
						fc_q <= fc_q + NW'(1);
					end
				end
				S_SPUT: begin
					if (chk_valid) begin
						h_home_q <= next_idx(h_home_q);
					end
				end
				S_SNEXT: begin
					ret_q <= S_IDLE;
					idx_q <= next_idx(idx_q);
					if (last_slot) begin
						bank_q <= !bank_q;
					end
				end
				default: ret_q <= ret_q;
			endcase
			if (state_q == S_SHASH && h_done) begin
				h_home_q <= h_home;
			end
		end
	end

	// request capture and pending result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q     <= mode;
				key_q      <= key;
				tag_q      <= TW'(type_tag);
				res_st_q   <= (mode == MODE_RESTART) ? ST_DONE : ST_NULL;
				res_due_q  <= 1'b0;
				res_fv_q   <= 1'b0;
				res_fk_q   <= '0;
				res_tag_q  <= '0;
				res_last_q <= 1'b1;
			end
			S_PCMP: begin
				if (mode_q == MODE_INSERT) begin
					res_due_q <= ({11'b0, live_q} >= thr_q);
					res_st_q  <= (!hit && full) ? ST_FULL : ST_DONE;
				end else if (!hit) begin
					res_st_q <= ST_ABSENT;
				end else if (rd_mark) begin
					res_st_q <= ST_MARKED;
				end else begin
					res_st_q  <= ST_DONE;
					res_tag_q <= rd_tag;
				end
			end
			S_SCHK: begin
				res_st_q   <= ST_DONE;
				res_due_q  <= 1'b0;
				res_fv_q   <= 1'b1;
				res_fk_q   <= rd_key;
				res_tag_q  <= rd_tag;
				res_last_q <= (fc_q + NW'(1) == nf_q);
			end
			S_SNEXT: begin
				res_st_q   <= ST_DONE;
				res_fv_q   <= 1'b0;
				res_fk_q   <= '0;
				res_tag_q  <= '0;
				res_last_q <= 1'b1;
			end
			S_EMIT: begin
				if (out_free) begin
					status_q <= res_st_q;
					due_q    <= res_due_q;
					fv_q     <= res_fv_q;
					fk_q     <= res_fk_q;
					etag_q   <= TAG_W'(res_tag_q);
					lc_q     <= live_q;
					last_q   <= res_last_q;
				end
			end
			default: res_st_q <= res_st_q;
		endcase
	end

	assign out_valid   = ov_q;
	assign status      = status_q;
	assign collect_due = due_q;
	assign freed_valid = fv_q;
	assign freed_key   = fk_q;
	assign entry_tag   = etag_q;
	assign live_count  = lc_q;
	assign last        = last_q;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import phsms_pkg::*;

	localparam int NSLOT = 64;
	localparam int WDOG_LIMIT = 20000;
	localparam int SETTLE = 1000;

	typedef struct {
		logic [2:0]  status;
		logic        due;
		logic        fv;
		logic [63:0] fk;
		logic [15:0] tag;
		logic [5:0]  live;
		logic        last;
	} gc_result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [63:0] key;
		logic [15:0] tag;
		bit          typed;
		logic [2:0]  st;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] mode = MODE_RESTART;
	logic [63:0] key = '0;
	logic [15:0] type_tag = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic collect_due, freed_valid, last;
	logic [63:0] freed_key;
	logic [15:0] entry_tag;
	logic [5:0] live_count;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = '0;

	// shadow allocation table
	logic [63:0] tbl_key[2*NSLOT];
	logic [15:0] tbl_tag[2*NSLOT];
	bit          tbl_mark[2*NSLOT];
	bit          act_bank;
	int unsigned live_n;
	logic [16:0] cur_thr;
	logic [15:0] init_thr;

	gc_result_t pending_q[$];
	int errors = 0;
	int idle_cnt = 0;
	int tx_pct = 0, rx_pct = 0;
	int hold_cycles = 0;
	bit typed_use = 0;
	logic [2:0] typed_st = ST_DONE;
	logic [63:0] key_pool[40];
	dir_row_t dir_tbl[$];

	pointer_hash_set_mark_sweep_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .key(key), .type_tag(type_tag),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .collect_due(collect_due), .freed_valid(freed_valid),
		.freed_key(freed_key), .entry_tag(entry_tag), .live_count(live_count),
		.last(last), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int home_of(logic [63:0] k);
		logic [63:0] h;
		h = (k >> 3) * GOLDEN;
		return int'(h[5:0]);
	endfunction

	function automatic void push_result(logic [2:0] st, logic due, logic fv,
			logic [63:0] fk, logic [15:0] tg, logic lst);
		gc_result_t r;
		r.status = st; r.due = due; r.fv = fv; r.fk = fk; r.tag = tg;
		r.live = live_n[5:0]; r.last = lst;
		pending_q.push_back(r);
	endfunction

	function automatic void clear_all();
		for (int i = 0; i < 2*NSLOT; i++) begin
			tbl_key[i] = '0; tbl_tag[i] = '0; tbl_mark[i] = 0;
		end
	endfunction

	function automatic void place(int bank, logic [63:0] k, logic [15:0] tg);
		int i;
		i = home_of(k);
		for (int n = 0; n < NSLOT; n++) begin
			if (tbl_key[bank*NSLOT + i] == 0) begin
				tbl_key[bank*NSLOT + i] = k;
				tbl_tag[bank*NSLOT + i] = tg;
				tbl_mark[bank*NSLOT + i] = 0;
				return;
			end
			i = (i + 1) % NSLOT;
		end
	endfunction

	function automatic int lookup(int bank, logic [63:0] k);
		int i;
		i = home_of(k);
		for (int n = 0; n < NSLOT; n++) begin
			if (tbl_key[bank*NSLOT + i] == 0) return -1;
			if (tbl_key[bank*NSLOT + i] == k) return i;
			i = (i + 1) % NSLOT;
		end
		return -1;
	endfunction

	// expected results of one collector request
	function automatic void predict_gc(logic [1:0] md, logic [63:0] k, logic [15:0] tg);
		int bank, other, pos, s, nfreed;
		logic due;
		logic [63:0] fk[$];
		logic [15:0] ft[$];
		bank = act_bank;
		other = bank ^ 1;
		if (md == MODE_RESTART) begin
			clear_all();
			act_bank = 0;
			live_n = 0;
			cur_thr = (init_thr != 0) ? {1'b0, init_thr} : DEFAULT_THR;
			push_result(ST_DONE, 0, 0, '0, '0, 1);
			return;
		end
		if (md == MODE_INSERT || md == MODE_MARK) begin
			if (k == 0) begin
				push_result(ST_NULL, 0, 0, '0, '0, 1);
				return;
			end
			pos = lookup(bank, k);
			if (md == MODE_INSERT) begin
				due = (live_n >= cur_thr);
				if (pos < 0) begin
					if ((live_n + 1) * 4 >= NSLOT * 3) begin
						push_result(ST_FULL, due, 0, '0, '0, 1);
						return;
					end
					place(bank, k, tg);
					live_n++;
				end
				push_result(ST_DONE, due, 0, '0, '0, 1);
			end else if (pos < 0) begin
				push_result(ST_ABSENT, 0, 0, '0, '0, 1);
			end else begin
				s = bank*NSLOT + pos;
				if (tbl_mark[s]) begin
					push_result(ST_MARKED, 0, 0, '0, '0, 1);
				end else begin
					tbl_mark[s] = 1;
					push_result(ST_DONE, 0, 0, '0, tbl_tag[s], 1);
				end
			end
			return;
		end
		// sweep: survivors move to the other bank, marks cleared
		for (int i = 0; i < NSLOT; i++) begin
			tbl_key[other*NSLOT + i] = '0;
			tbl_tag[other*NSLOT + i] = '0;
			tbl_mark[other*NSLOT + i] = 0;
		end
		live_n = 0;
		for (int i = 0; i < NSLOT; i++) begin
			s = bank*NSLOT + i;
			if (tbl_key[s] != 0) begin
				if (tbl_mark[s]) begin
					place(other, tbl_key[s], tbl_tag[s]);
					live_n++;
				end else begin
					fk.push_back(tbl_key[s]);
					ft.push_back(tbl_tag[s]);
				end
				tbl_key[s] = '0; tbl_tag[s] = '0; tbl_mark[s] = 0;
			end
		end
		act_bank = other;
		if (cur_thr == 0) cur_thr = 1;
		while (live_n > (cur_thr >> 1)) cur_thr = cur_thr << 1;
		nfreed = fk.size();
		if (nfreed == 0) push_result(ST_DONE, 0, 0, '0, '0, 1);
		for (int i = 0; i < nfreed; i++)
			push_result(ST_DONE, 0, 1, fk[i], ft[i], i == nfreed - 1);
	endfunction

	function automatic void field_check(string nm, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
			errors++;
		end
	endfunction

	// transfer monitor: check results, predict on accepted requests
	always @(posedge clk) begin
		gc_result_t e;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d key %0h",
					$time, status, freed_key);
				errors++;
			end else begin
				e = pending_q.pop_front();
				field_check("status", e.status, status);
				field_check("collect_due", e.due, collect_due);
				field_check("freed_valid", e.fv, freed_valid);
				field_check("freed_key", e.fk, freed_key);
				field_check("entry_tag", e.tag, entry_tag);
				field_check("live_count", e.live, live_count);
				field_check("last", e.last, last);
			end
		end
		if (in_valid && in_ready) begin
			predict_gc(mode, key, type_tag);
			if (typed_use) pending_q[pending_q.size()-1].status = typed_st;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_pct);
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send(logic [1:0] md, logic [63:0] k, logic [15:0] tg,
			bit tu = 0, logic [2:0] ts = ST_DONE);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		mode <= md; key <= k; type_tag <= tg;
		typed_use = tu; typed_st = ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_thr(logic [15:0] v);
		in_valid <= 0;
		@(negedge clk);
		while (pending_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		init_thr = v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		// half the keys share home bits so probe chains form
		if ($urandom_range(1)) k[8:3] = 6'h15;
		if (k == 0) k = 64'h8;
		return k;
	endfunction

	// restart then run the table to full, mark some, sweep
	task automatic fill_burst();
		logic [63:0] ks[$];
		send(MODE_RESTART, rand_key(), $urandom);
		for (int j = 0; j < 50; j++) begin
			ks.push_back(rand_key());
			send(MODE_INSERT, ks[j], $urandom);
		end
		for (int j = 0; j < 12; j++)
			send(MODE_MARK, ks[$urandom_range(49)], $urandom);
		send(MODE_SWEEP, rand_key(), $urandom);
	endtask

	task automatic random_items(int n);
		int r;
		logic [63:0] k;
		for (int j = 0; j < n; j++) begin
			r = $urandom_range(99);
			k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(39)] : rand_key();
			if ($urandom_range(99) < 5) key_pool[$urandom_range(39)] = rand_key();
			if (r < 45) send(MODE_INSERT, k, $urandom);
			else if (r < 80) send(MODE_MARK, k, $urandom);
			else if (r < 87) send(MODE_SWEEP, {$urandom, $urandom}, $urandom);
			else if (r < 90) send(MODE_RESTART, {$urandom, $urandom}, $urandom);
			else if (r < 95) send($urandom_range(1) ? MODE_INSERT : MODE_MARK, '0, $urandom);
			else send(MODE_INSERT, rand_key(), $urandom);
		end
	endtask

	initial begin
		logic [15:0] thr_set[4];
		int tx_tab[4];
		int rx_tab[4];
		thr_set = '{16'd1, 16'd65535, 16'd3, 16'd100};
		tx_tab = '{0, 86, 0, 28};
		rx_tab = '{0, 0, 86, 28};
		clear_all();
		act_bank = 0; live_n = 0; cur_thr = DEFAULT_THR; init_thr = 16'd100;
		foreach (key_pool[i]) key_pool[i] = rand_key();

		// directed rows: status typed where obvious, else predicted
		dir_tbl = '{
			'{MODE_RESTART, 64'h0, 16'h0, 1, ST_DONE},
			'{MODE_INSERT, 64'h0, 16'hFFFF, 1, ST_NULL},
			'{MODE_MARK, 64'h0, 16'h0, 1, ST_NULL},
			'{MODE_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1, ST_ABSENT},
			'{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1, ST_DONE},
			'{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234, 1, ST_DONE},
			'{MODE_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 0, ST_DONE},
			'{MODE_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1, ST_MARKED},
			'{MODE_INSERT, 64'h1, 16'h0, 0, ST_DONE},
			'{MODE_INSERT, 64'h8, 16'h0001, 0, ST_DONE},
			'{MODE_INSERT, 64'h208, 16'h8000, 0, ST_DONE},
			'{MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 0, ST_DONE},
			'{MODE_INSERT, 64'h5555_5555_5555_5555, 16'hAAAA, 0, ST_DONE},
			'{MODE_INSERT, 64'h8000_0000_0000_0000, 16'h7FFF, 0, ST_DONE},
			'{MODE_MARK, 64'h208, 16'h0, 0, ST_DONE},
			'{MODE_MARK, 64'h5555_5555_5555_5555, 16'h0, 0, ST_DONE},
			'{MODE_SWEEP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0, ST_DONE},
			'{MODE_MARK, 64'h8, 16'h0, 1, ST_ABSENT},
			'{MODE_MARK, 64'h208, 16'h0, 0, ST_DONE},
			'{MODE_SWEEP, 64'h0, 16'h0, 0, ST_DONE},
			'{MODE_SWEEP, 64'h0, 16'h0, 0, ST_DONE},
			'{MODE_SWEEP, 64'h0, 16'h0, 0, ST_DONE},
			'{MODE_RESTART, 64'h0, 16'h0, 1, ST_DONE}
		};

		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			tx_pct = tx_tab[ph];
			rx_pct = rx_tab[ph];
			write_thr(thr_set[ph]);
			send(MODE_RESTART, '0, '0);
			if (ph == 0) begin
				foreach (dir_tbl[i])
					send(dir_tbl[i].mode, dir_tbl[i].key, dir_tbl[i].tag,
						dir_tbl[i].typed, dir_tbl[i].st);
				// receiver holds off while requests keep coming
				hold_cycles = 400;
			end
			random_items(30);
			fill_burst();
		end
		in_valid <= 0;
		typed_use = 0;

		while (pending_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
